// ----- rtl/percent_decode_stream_assert.svh -----
// ---------------------------------------------------------------------------
// Percent decode stream assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef PERCENT_DECODE_STREAM_ASSERT_SVH
`define PERCENT_DECODE_STREAM_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define PDS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pds_pkg.sv -----
// ---------------------------------------------------------------------------
// Percent decode stream package
// Character codes, escape state, result types and hex digit helpers.
// ---------------------------------------------------------------------------
package pds_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Result queue geometry.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTRW  = $clog2(QDEPTH);
  localparam int unsigned QCNTW  = $clog2(QDEPTH + 1);

  // Most bytes that one item can produce.
  localparam int unsigned MAXRES = 3;

  // Open escape: nothing held, '%' held, or '%' plus one hex digit held.
  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_PCT   = 2'd1,
    PEND_DIGIT = 2'd2
  } pds_pend_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } pds_res_t;

  // Results of one item, in order, with their count.
  typedef struct packed {
    pds_res_t [MAXRES-1:0] res;
    logic [1:0]            cnt;
  } pds_batch_t;

  function automatic logic is_hex(input logic [7:0] b);
    is_hex = (b >= 8'h30 && b <= 8'h39) ||
             (b >= 8'h61 && b <= 8'h66) ||
             (b >= 8'h41 && b <= 8'h46);
  endfunction

  // Nibble value of a hex digit; letters of either case map to 10..15.
  function automatic logic [3:0] hex_val(input logic [7:0] b);
    if (b <= 8'h39) begin
      hex_val = b[3:0];
    end else begin
      hex_val = b[3:0] + 4'd9;
    end
  endfunction

endpackage

// ----- rtl/pds_stream_if.sv -----
// ---------------------------------------------------------------------------
// Percent decode stream channels
// Valid/ready channels for encoded input items and decoded result items.
// ---------------------------------------------------------------------------
interface pds_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface pds_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ----- rtl/pds_decode.sv -----
// ---------------------------------------------------------------------------
// Percent decode stream decoder
// Escape state registers and the per-item decode into up to three bytes.
// ---------------------------------------------------------------------------
module pds_decode
  import pds_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output pds_batch_t batch_o
);

  localparam int unsigned NCAND = 5;

  pds_pend_e  pend_q, pend_d, mid_pend;
  logic [7:0] digit_q;
  logic       hex_b, is_pct;
  logic [7:0] plain_val;

  logic [NCAND-1:0] cand_en;
  logic [7:0]       cand_val [NCAND];

  assign hex_b     = is_hex(byte_i);
  assign is_pct    = (byte_i == CH_PERCENT);
  assign plain_val = (byte_i == CH_PLUS) ? CH_SPACE : byte_i;

  // Next escape state; mid_pend is the state before the end-of-string flush.
  always_comb begin
    unique case (pend_q)
      PEND_NONE: begin
        mid_pend = is_pct ? PEND_PCT : PEND_NONE;
      end
      PEND_PCT: begin
        mid_pend = hex_b ? PEND_DIGIT : (is_pct ? PEND_PCT : PEND_NONE);
      end
      default: begin
        mid_pend = hex_b ? PEND_NONE : (is_pct ? PEND_PCT : PEND_NONE);
      end
    endcase
    pend_d = pend_q;
    if (accept_i) begin
      pend_d = last_i ? PEND_NONE : mid_pend;
    end
  end

  // Candidate bytes in emission order: literal '%' of a broken escape, the
  // held digit of a broken escape, the byte itself (plain or decoded), then
  // the end-of-string flush of '%' and of a freshly held digit.
  always_comb begin
    cand_en     = '0;
    cand_val[0] = CH_PERCENT;
    cand_val[1] = digit_q;
    cand_val[2] = plain_val;
    cand_val[3] = CH_PERCENT;
    cand_val[4] = byte_i;
    unique case (pend_q)
      PEND_NONE: begin
        cand_en[2] = !is_pct;
      end
      PEND_PCT: begin
        cand_en[0] = !hex_b;
        cand_en[2] = !hex_b && !is_pct;
      end
      default: begin
        if (hex_b) begin
          cand_en[2] = 1'b1;
          cand_val[2] = {hex_val(digit_q), hex_val(byte_i)};
        end else begin
          // The held digit is always a hex digit, so it passes as itself.
          cand_en[0] = 1'b1;
          cand_en[1] = 1'b1;
          cand_en[2] = !is_pct;
        end
      end
    endcase
    cand_en[3] = last_i && (mid_pend != PEND_NONE);
    cand_en[4] = last_i && (mid_pend == PEND_DIGIT);
  end

  // Pack the enabled candidates into consecutive slots.
  always_comb begin
    logic [1:0] idx;
    idx     = '0;
    batch_o = '0;
    for (int k = 0; k < NCAND; k++) begin
      if (cand_en[k] && idx != 2'(MAXRES)) begin
        batch_o.res[idx].data = cand_val[k];
        idx = idx + 2'd1;
      end
    end
    batch_o.cnt = idx;
    for (int i = 0; i < MAXRES; i++) begin
      batch_o.res[i].last = last_i && ((2'(i) + 2'd1) == idx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= PEND_NONE;
    end else begin
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && pend_q == PEND_PCT && hex_b) begin
      digit_q <= byte_i;
    end
  end

endmodule

// ----- rtl/pds_outq.sv -----
// ---------------------------------------------------------------------------
// Percent decode stream result queue
// Four-entry queue that takes up to three bytes at once and sends one a cycle when ready_i is high.
// ---------------------------------------------------------------------------
module pds_outq
  import pds_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  pds_batch_t batch_i,
  output logic       space_o,
  output logic       valid_o,
  input  logic       ready_i,
  output pds_res_t   head_o
);

  pds_res_t         entry_q [QDEPTH];
  logic [QPTRW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCNTW-1:0] cnt_q, cnt_d;
  logic [QCNTW-1:0] push_n;
  logic             pop;

  // Room for a full batch whatever the output side does this cycle.
  assign space_o = (cnt_q <= QCNTW'(QDEPTH - MAXRES));
  assign valid_o = (cnt_q != '0);
  assign head_o  = entry_q[rptr_q];
  assign pop     = valid_o && ready_i;
  assign push_n  = push_i ? QCNTW'(batch_i.cnt) : '0;

  always_comb begin
    wptr_d = wptr_q + QPTRW'(push_n);
    rptr_d = rptr_q + QPTRW'(pop);
    cnt_d  = cnt_q + push_n - QCNTW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAXRES; i++) begin
      if (push_i && (2'(i) < batch_i.cnt)) begin
        entry_q[wptr_q + QPTRW'(i)] <= batch_i.res[i];
      end
    end
  end

endmodule

// ----- rtl/percent_decode_stream.sv -----
// Results: an item's bytes are queued and leave on the output channel in order.
// Throughput: one item per cycle while items yield at most one byte each and
//   the sink takes every byte; the single output port drains one byte a cycle,
//   so an item that yields two or three bytes holds off input until the
//   four-entry result queue has room for a full batch.
// Reset: rst_ni clears the escape state and the result queue; no clearing pass.
// ---------------------------------------------------------------------------
// Percent decode stream top level
// Decodes %XX escapes and '+' in a byte stream, one input byte per cycle while the queue has room.
// ---------------------------------------------------------------------------
module percent_decode_stream
  import pds_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  pds_in_if.sink       in_i,
  pds_out_if.source    out_o
);

  // An item is taken whenever the result queue can hold a full batch of three
  // bytes. The decoder works straight off the incoming byte and its escape
  // state registers, and the batch lands in the queue at the same edge.
  logic       accept;
  logic       space;
  pds_batch_t batch;
  pds_res_t   head;

  assign in_i.ready = space;
  assign accept     = in_i.valid && space;

  pds_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (in_i.in_byte),
    .last_i   (in_i.in_last),
    .batch_o  (batch)
  );

  // The queue entries double as the output register: the head entry drives
  // the output payload directly and holds while the sink stalls.
  pds_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .batch_i (batch),
    .space_o (space),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .head_o  (head)
  );

  assign out_o.out_byte = head.data;
  assign out_o.out_last = head.last;

endmodule

// ----- rtl/pds_checker.sv -----
// ---------------------------------------------------------------------------
// Percent decode stream checker
// Port-level assertions on the decoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "percent_decode_stream_assert.svh"

module pds_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_last_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_last_i
);

  // A stalled result stays offered and unchanged.
  `PDS_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")
  `PDS_ASSERT_NEXT(a_out_stable, out_valid_i && !out_ready_i, $stable(out_byte_i) && $stable(out_last_i), "result changed while stalled")

  // The final byte of a string always yields at least one result.
  `PDS_ASSERT_NEXT(a_last_yields, in_valid_i && in_ready_i && in_last_i, out_valid_i, "final byte gave no result")

  // With nothing waiting on the output, the input side must be open.
  `PDS_ASSERT_SAME(a_ready_when_empty, !out_valid_i, in_ready_i, "input blocked with empty output")

endmodule

bind percent_decode_stream pds_checker u_pds_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.in_last),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .out_last_i  (out_o.out_last)
);
